FILE: design/uers_pkg.sv
// Shared types, constants and codes for the UTF-8 emoji run splitter.
package uers_pkg;

   localparam int MaxResults        = 3;
   localparam int QueueDepthDefault = 4;

   localparam logic [20:0] CpJoiner      = 21'h0200D;
   localparam logic [20:0] CpVariation   = 21'h0FE0F;
   localparam logic [20:0] CpKeycap      = 21'h020E3;
   localparam logic [20:0] CpSkinLow     = 21'h1F3FB;
   localparam logic [20:0] CpSkinHigh    = 21'h1F3FF;
   localparam logic [20:0] CpRegionLow   = 21'h1F1E6;
   localparam logic [20:0] CpRegionHigh  = 21'h1F1FF;
   localparam logic [20:0] CpSymbolLow   = 21'h02600;
   localparam logic [20:0] CpSymbolHigh  = 21'h027BF;
   localparam logic [20:0] CpPictLow     = 21'h1F300;
   localparam logic [20:0] CpPictHigh    = 21'h1FAFF;
   localparam logic [20:0] CpSupplLow    = 21'h1F900;

   typedef enum logic [1:0] {
      MODE_NONE,
      MODE_TEXT,
      MODE_EMOJI,
      MODE_AFTER_JOINER
   } run_mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [20:0] codepoint;
      logic        in_emoji_run;
      logic        starts_run;
      logic        final_result;
   } rsp_type;

   typedef struct packed {
      logic [1:0]       count;
      logic [2:0][20:0] cp;
   } dec_type;

   typedef struct packed {
      logic [1:0]    count;
      rsp_type [2:0] item;
   } batch_type;

   typedef struct packed {
      run_mode_type mode;
      logic         prior_regional;
      logic         emoji;
      logic         starts;
   } emit_type;

endpackage

FILE: design/uers_decode.sv
// Lenient UTF-8 byte assembly with re-split of a truncated sequence at end of string.
module uers_decode (
   input  logic             clock,
   input  logic             reset,
   input  logic             advance,
   input  logic [7:0]       data_byte,
   input  logic             end_of_string,
   output uers_pkg::dec_type dec
);

   function automatic logic [2:0] seq_len(input logic [7:0] b);
      logic [2:0] len;
      priority if (b[7] == 1'b0)        len = 3'd1;
      else if (b[7:5] == 3'b110)        len = 3'd2;
      else if (b[7:4] == 4'b1110)       len = 3'd3;
      else if (b[7:3] == 5'b11110)      len = 3'd4;
      else                              len = 3'd1;
      return len;
   endfunction

   function automatic logic [20:0] byte_cp(input logic [7:0] b);
      return {13'd0, b};
   endfunction

   logic [7:0] held_ff [3];
   logic [7:0] held_in [3];
   logic [1:0] held_count_ff, held_count_in;
   logic [1:0] expected_ff, expected_in;
   logic [2:0] lead_len;
   logic [1:0] rem;
   logic [20:0] cp_full;

   always_comb begin
      lead_len = seq_len(data_byte);
      if (held_count_ff == 2'd0) begin
         rem = 2'(lead_len - 3'd1);
      end else begin
         rem = (expected_ff != 2'd0) ? expected_ff - 2'd1 : 2'd0;
      end

      unique case (held_count_ff)
         2'd0: cp_full = byte_cp(data_byte);
         2'd1: cp_full = {10'd0, held_ff[0][4:0], data_byte[5:0]};
         2'd2: cp_full = {5'd0, held_ff[0][3:0], held_ff[1][5:0], data_byte[5:0]};
         2'd3: cp_full = {held_ff[0][2:0], held_ff[1][5:0], held_ff[2][5:0],
                          data_byte[5:0]};
      endcase

      dec           = '0;
      held_in       = held_ff;
      held_count_in = held_count_ff;
      expected_in   = expected_ff;

      if (rem == 2'd0) begin
         dec.count     = 2'd1;
         dec.cp[0]     = cp_full;
         held_count_in = 2'd0;
         expected_in   = 2'd0;
      end else if (end_of_string) begin
         unique case (held_count_ff)
            2'd0: begin
               dec.count = 2'd1;
               dec.cp[0] = byte_cp(data_byte);
            end
            2'd1: begin
               dec.count = 2'd2;
               dec.cp[0] = byte_cp(held_ff[0]);
               dec.cp[1] = byte_cp(data_byte);
            end
            default: begin
               dec.cp[0] = byte_cp(held_ff[0]);
               if (seq_len(held_ff[1]) == 3'd2) begin
                  dec.count = 2'd2;
                  dec.cp[1] = {10'd0, held_ff[1][4:0], data_byte[5:0]};
               end else begin
                  dec.count = 2'd3;
                  dec.cp[1] = byte_cp(held_ff[1]);
                  dec.cp[2] = byte_cp(data_byte);
               end
            end
         endcase
      end else begin
         if (held_count_ff != 2'd3) begin
            held_in[held_count_ff] = data_byte;
         end
         held_count_in = held_count_ff + 2'd1;
         expected_in   = rem;
      end

      if (end_of_string) begin
         held_count_in = 2'd0;
         expected_in   = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_count_ff <= 2'd0;
         expected_ff   <= 2'd0;
      end else if (advance) begin
         held_count_ff <= held_count_in;
         expected_ff   <= expected_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         held_ff <= held_in;
      end
   end

   a_eos_clears_hold: assert property (@(posedge clock) disable iff (reset)
      advance && end_of_string |=> held_count_ff == 2'd0 && expected_ff == 2'd0)
      else $error("hold not cleared at end of string");

endmodule

FILE: design/uers_classify.sv
// Emoji and text run marking for up to three codepoints of one byte.
module uers_classify (
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               end_of_string,
   input  uers_pkg::dec_type  dec,
   output uers_pkg::batch_type batch
);

   function automatic logic is_regional(input logic [20:0] cp);
      return cp >= uers_pkg::CpRegionLow && cp <= uers_pkg::CpRegionHigh;
   endfunction

   function automatic logic is_starter(input logic [20:0] cp);
      return (cp >= uers_pkg::CpSymbolLow && cp <= uers_pkg::CpSymbolHigh)
          || (cp >= uers_pkg::CpPictLow && cp <= uers_pkg::CpPictHigh)
          || (cp >= uers_pkg::CpSupplLow && cp <= uers_pkg::CpPictHigh)
          || is_regional(cp);
   endfunction

   function automatic uers_pkg::emit_type emit_step(input uers_pkg::run_mode_type mode,
                                                    input logic prior,
                                                    input logic [20:0] cp);
      uers_pkg::emit_type r;
      logic joined;
      logic starter;
      logic regional;
      logic modifier;
      starter  = is_starter(cp);
      regional = is_regional(cp);
      modifier = cp == uers_pkg::CpVariation || cp == uers_pkg::CpKeycap
              || (cp >= uers_pkg::CpSkinLow && cp <= uers_pkg::CpSkinHigh);
      r.mode           = mode;
      r.prior_regional = prior;
      r.emoji          = 1'b0;
      r.starts         = 1'b0;
      joined           = 1'b0;
      if (mode == uers_pkg::MODE_AFTER_JOINER) begin
         if (starter) begin
            joined           = 1'b1;
            r.mode           = uers_pkg::MODE_EMOJI;
            r.prior_regional = regional;
         end
      end else if (mode == uers_pkg::MODE_EMOJI) begin
         if (modifier) begin
            joined           = 1'b1;
            r.prior_regional = 1'b0;
         end else if (cp == uers_pkg::CpJoiner) begin
            joined           = 1'b1;
            r.mode           = uers_pkg::MODE_AFTER_JOINER;
            r.prior_regional = 1'b0;
         end else if (regional && prior) begin
            joined           = 1'b1;
            r.prior_regional = 1'b1;
         end
      end
      if (joined) begin
         r.emoji = 1'b1;
      end else if (starter) begin
         r.emoji          = 1'b1;
         r.starts         = 1'b1;
         r.mode           = uers_pkg::MODE_EMOJI;
         r.prior_regional = regional;
      end else begin
         r.starts         = mode != uers_pkg::MODE_TEXT;
         r.mode           = uers_pkg::MODE_TEXT;
         r.prior_regional = 1'b0;
      end
      return r;
   endfunction

   uers_pkg::run_mode_type mode_ff, mode_in;
   logic                   prior_ff, prior_in;
   uers_pkg::run_mode_type mode_c [4];
   logic                   prior_c [4];
   uers_pkg::emit_type     step [3];

   always_comb begin
      mode_c[0]   = mode_ff;
      prior_c[0]  = prior_ff;
      batch.count = dec.count;
      for (int k = 0; k < 3; k++) begin
         step[k] = emit_step(mode_c[k], prior_c[k], dec.cp[k]);
         batch.item[k].codepoint    = dec.cp[k];
         batch.item[k].in_emoji_run = step[k].emoji;
         batch.item[k].starts_run   = step[k].starts;
         batch.item[k].final_result = end_of_string && (dec.count == 2'(k + 1));
         if (2'(k) < dec.count) begin
            mode_c[k + 1]  = step[k].mode;
            prior_c[k + 1] = step[k].prior_regional;
         end else begin
            mode_c[k + 1]  = mode_c[k];
            prior_c[k + 1] = prior_c[k];
         end
      end
      if (end_of_string) begin
         mode_in  = uers_pkg::MODE_NONE;
         prior_in = 1'b0;
      end else begin
         mode_in  = mode_c[3];
         prior_in = prior_c[3];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= uers_pkg::MODE_NONE;
         prior_ff <= 1'b0;
      end else if (advance) begin
         mode_ff  <= mode_in;
         prior_ff <= prior_in;
      end
   end

   a_eos_clears_run: assert property (@(posedge clock) disable iff (reset)
      advance && end_of_string |=> mode_ff == uers_pkg::MODE_NONE && !prior_ff)
      else $error("run state not cleared at end of string");

   a_regional_in_emoji: assert property (@(posedge clock) disable iff (reset)
      prior_ff |-> mode_ff == uers_pkg::MODE_EMOJI)
      else $error("regional mark outside an emoji run");

endmodule

FILE: design/uers_queue.sv
// Result queue: takes up to three results at once, hands out one per transaction.
module uers_queue #(
   parameter int Depth = uers_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  uers_pkg::batch_type batch,
   output logic                has_room,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output uers_pkg::rsp_type   rsp_payload
);

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [CntW-1:0] MaxFill  = CntW'(Depth - uers_pkg::MaxResults);
   localparam logic [CntW-1:0] DepthCnt = CntW'(Depth);
   localparam logic [PtrW:0]   DepthSum = (PtrW + 1)'(Depth);

   function automatic logic [PtrW-1:0] wrap_add(input logic [PtrW-1:0] ptr,
                                                input logic [1:0] k);
      logic [PtrW:0] s;
      s = {1'b0, ptr} + (PtrW + 1)'(k);
      if (s >= DepthSum) begin
         s = s - DepthSum;
      end
      return s[PtrW-1:0];
   endfunction

   uers_pkg::rsp_type mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]   count_ff, count_in;
   logic              pop;

   always_comb begin
      rsp_valid   = count_ff != '0;
      rsp_payload = mem_ff[rd_ptr_ff];
      has_room    = count_ff <= MaxFill;
      pop         = rsp_valid && !rsp_stall;
      wr_ptr_in   = push ? wrap_add(wr_ptr_ff, batch.count) : wr_ptr_ff;
      rd_ptr_in   = pop ? wrap_add(rd_ptr_ff, 2'd1) : rd_ptr_ff;
      count_in    = count_ff + (push ? CntW'(batch.count) : '0) - (pop ? CntW'(1) : '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         for (int k = 0; k < uers_pkg::MaxResults; k++) begin
            if (2'(k) < batch.count) begin
               mem_ff[wrap_add(wr_ptr_ff, 2'(k))] <= batch.item[k];
            end
         end
      end
   end

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DepthCnt)
      else $error("result queue overfilled");

   a_push_with_room: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff <= MaxFill)
      else $error("results pushed without room");

endmodule

FILE: design/utf8_emoji_run_splitter_unit.sv
// Top level of the UTF-8 decoder that splits codepoints into text and emoji runs.
//
//   channel  dir  ports                          payload
//   req      in   req_valid / req_stall          req_type: data_byte, end_of_string
//   rsp      out  rsp_valid / rsp_stall          rsp_type: codepoint, marks
//
// One byte per cycle while the queue has room: a byte waits in the input register until
// the queue has room, then its codepoints enter the result queue, which offers them in order.
// A truncated sequence at end of string yields up to three queued results, drained one per
// cycle while rsp_stall is low; input stalls while the queue lacks room for three results.
// Synchronous reset clears the hold, run state, input register and queue.
module utf8_emoji_run_splitter_unit #(
   parameter int QueueDepth = uers_pkg::QueueDepthDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  uers_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output uers_pkg::rsp_type rsp_payload
);

   logic                stage_valid_ff, stage_valid_in;
   uers_pkg::req_type   stage_ff;
   logic                has_room;
   logic                advance;
   logic                accept;
   uers_pkg::dec_type   dec;
   uers_pkg::batch_type batch;

   always_comb begin
      advance   = stage_valid_ff && has_room;
      req_stall = stage_valid_ff && !has_room;
      accept    = req_valid && !req_stall;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end else begin
         stage_valid_in = stage_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         stage_ff <= req_payload;
      end
   end

   uers_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .data_byte     (stage_ff.data_byte),
      .end_of_string (stage_ff.end_of_string),
      .dec           (dec)
   );

   uers_classify u_classify (
      .clock         (clock),
      .reset         (reset),
      .advance       (advance),
      .end_of_string (stage_ff.end_of_string),
      .dec           (dec),
      .batch         (batch)
   );

   uers_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock       (clock),
      .reset       (reset),
      .push        (advance),
      .batch       (batch),
      .has_room    (has_room),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && !has_room |=> stage_valid_ff && $stable(stage_ff))
      else $error("input register lost a waiting byte");

endmodule
